>>> design/gna_pkg.sv
// ----------------------------------------------------------------------------
// gna_pkg: shared types and constants for the gauge needle reader
// Holds field widths, the CORDIC arctangent table, the pressure segment
// constants and the meter type codes.
// ----------------------------------------------------------------------------
package gna_pkg;

    // Fixed field widths of the stream items.
    localparam int FIELD_W   = 12;   // each coordinate field
    localparam int ANGLE_W   = 15;   // needle angle in 1/64 degree
    localparam int PRES_W    = 14;   // pressure in 0.0001 MPa

    // Defaults for the top level parameters.
    localparam int COORD_BITS_DEF    = 12;
    localparam int CORDIC_STAGES_DEF = 16;

    // CORDIC arithmetic.
    localparam int ATAN_LEN  = 24;   // entries in the arctangent table
    localparam int PRESCALE  = 24;   // fractional bits of the rotator datapath
    localparam int ACC_W     = 24;   // angle accumulator, 1/16384 degree, signed

    localparam logic [ACC_W-1:0] HALF_TURN_FINE = ACC_W'(2949120);
    localparam logic [ACC_W-1:0] FULL_TURN_FINE = ACC_W'(5898240);
    localparam logic [ACC_W-1:0] ROUND_HALF     = ACC_W'(128);
    localparam int               FINE_SHIFT     = 8;
    localparam logic [ANGLE_W-1:0] FULL_TURN_64 = ANGLE_W'(23040);

    // atan(2^-i) in 1/16384 degree, rounded.
    localparam logic [22:0] ATAN_TAB [ATAN_LEN] = '{
        23'd737280, 23'd435242, 23'd229970, 23'd116736,
        23'd58595,  23'd29326,  23'd14667,  23'd7334,
        23'd3667,   23'd1833,   23'd917,    23'd458,
        23'd229,    23'd115,    23'd57,     23'd29,
        23'd14,     23'd7,      23'd4,      23'd2,
        23'd1,      23'd0,      23'd0,      23'd0
    };

    // Pressure scale. Every segment is scaled so that full scale reads
    // 4032000, then the meter type picks the final rational factor.
    localparam int M_W   = 22;
    localparam int V_W   = 20;

    localparam logic [ANGLE_W-1:0] SEG_LOW_START = ANGLE_W'(14592); // 228 degrees
    localparam logic [ANGLE_W-1:0] SEG_TOP_START = ANGLE_W'(17280); // 270 degrees
    localparam logic [ANGLE_W-1:0] RIGHT_ANGLE   = ANGLE_W'(5760);  //  90 degrees
    localparam logic [ANGLE_W-1:0] SEG_END       = ANGLE_W'(8448);  // 132 degrees

    localparam logic [7:0] SLOPE_OUTER = 8'd240;
    localparam logic [7:0] SLOPE_INNER = 8'd238;

    localparam logic [M_W-1:0] OFF_LOW   = M_W'(0);
    localparam logic [M_W-1:0] OFF_TOP   = M_W'(645120);
    localparam logic [M_W-1:0] OFF_RIGHT = M_W'(2016000);
    localparam logic [M_W-1:0] OFF_HIGH  = M_W'(3386880);

    // Per meter type: pressure = ((c*M + bias) >> shift) / 63.
    localparam int SUM_W = 25;
    localparam logic [SUM_W-1:0] BIAS_1_0  = SUM_W'(1008);
    localparam logic [SUM_W-1:0] BIAS_0_25 = SUM_W'(4032);
    localparam logic [SUM_W-1:0] BIAS_1_6  = SUM_W'(126);
    localparam int SHIFT_1_0  = 5;
    localparam int SHIFT_0_25 = 7;
    localparam int SHIFT_1_6  = 2;

    // Division by 63 as a multiplication by the rounded-up reciprocal.
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_63 = RECIP_W'(1065221);

    typedef enum logic [1:0] {
        MT_UNKNOWN = 2'd0,
        MT_1_0     = 2'd1,
        MT_0_25    = 2'd2,
        MT_1_6     = 2'd3
    } t_meter;

endpackage

>>> design/gna_cordic_stage.sv
// ----------------------------------------------------------------------------
// gna_cordic_stage: one registered micro-rotation of the vectoring CORDIC
// Rotates the vector towards the positive x axis by atan(2^-IDX) and
// accumulates the angle turned.
// ----------------------------------------------------------------------------
module gna_cordic_stage
    import gna_pkg::*;
#(
    parameter int W   = 39,
    parameter int IDX = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [W-1:0]     i_x,
    input  logic signed [W-1:0]     i_y,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic signed [W-1:0]     o_x,
    output logic signed [W-1:0]     o_y,
    output logic signed [ACC_W-1:0] o_acc
);

    localparam logic signed [ACC_W-1:0] ATAN = ACC_W'(ATAN_TAB[IDX]);

    logic signed [W-1:0]     xs;
    logic signed [W-1:0]     ys;
    logic signed [W-1:0]     n_x;
    logic signed [W-1:0]     n_y;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [W-1:0]     r_x;
    logic signed [W-1:0]     r_y;
    logic signed [ACC_W-1:0] r_acc;

    // Arithmetic shifts floor towards minus infinity.
    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;

    always_comb begin
        if (i_y < 0) begin
            n_x   = i_x - ys;
            n_y   = i_y + xs;
            n_acc = i_acc - ATAN;
        end else begin
            n_x   = i_x + ys;
            n_y   = i_y - xs;
            n_acc = i_acc + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_acc <= n_acc;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_acc = r_acc;

endmodule

>>> design/gauge_needle_angle_to_pressure.sv
// ----------------------------------------------------------------------------
// gauge_needle_angle_to_pressure: needle segment to dial angle and pressure
// Picks the needle tip, finds its clockwise angle from 12 o'clock with a
// pipelined CORDIC and maps the angle to a pressure reading.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata (low bit first)                 tuser
//  s_axis    in         center_x, center_y, end_a_x, end_a_y,  dial_kind
//                       end_b_x, end_b_y (72 bits)
//  m_axis    out        needle_angle, pressure, zero fill      angle_valid
//                       (32 bits)
//
//  One item enters per clock cycle while the skid register is empty. The
//  pipeline holds NS + 7 register stages, NS being CORDIC_STAGES clamped to
//  24: three set-up stages, one stage per CORDIC micro-rotation and four
//  stages of angle rounding and pressure mapping. The first stage loads at
//  the accepting edge, and the item is presented from the last stage.
//  Reset is synchronous and active low; it empties the pipeline and the skid
//  register. When the output is stalled, one finished item is parked in a skid
//  register and the whole pipeline then holds, so s_axis_tready depends only
//  on registered state.
//
module gauge_needle_angle_to_pressure
    import gna_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Needle segment items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // center_x, center_y, end_a_x, end_a_y, end_b_x, end_b_y
    input  logic [1:0]  s_axis_tuser,  // dial_kind
    // Reading items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // needle_angle[14:0], pressure[28:15], zero [31:29]
    output logic [0:0]  m_axis_tuser   // angle_valid
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int NS    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int DW    = COORD_BITS + 1;        // signed pixel difference
    localparam int SQ_W  = 2 * COORD_BITS + 2;    // squared distance, signed
    localparam int W     = COORD_BITS + 3 + PRESCALE;  // rotator datapath
    localparam int L     = NS + 7;                // pipeline depth

    // The pipeline moves whenever the skid register is free.
    logic en;
    logic [L-1:0] r_vld;

    // ------------------------------------------------------------------
    // Stage 1: unpack, keep the low COORD_BITS of each coordinate and take
    // the differences from the dial centre.
    // ------------------------------------------------------------------
    logic [EXT_W-1:0]      ext_cx, ext_cy, ext_ax, ext_ay, ext_bx, ext_by;
    logic [COORD_BITS-1:0] cx, cy, ax, ay, bx, by;

    assign ext_cx = EXT_W'(s_axis_tdata[11:0]);
    assign ext_cy = EXT_W'(s_axis_tdata[23:12]);
    assign ext_ax = EXT_W'(s_axis_tdata[35:24]);
    assign ext_ay = EXT_W'(s_axis_tdata[47:36]);
    assign ext_bx = EXT_W'(s_axis_tdata[59:48]);
    assign ext_by = EXT_W'(s_axis_tdata[71:60]);

    assign cx = ext_cx[COORD_BITS-1:0];
    assign cy = ext_cy[COORD_BITS-1:0];
    assign ax = ext_ax[COORD_BITS-1:0];
    assign ay = ext_ay[COORD_BITS-1:0];
    assign bx = ext_bx[COORD_BITS-1:0];
    assign by = ext_by[COORD_BITS-1:0];

    logic signed [DW-1:0] r1_ax, r1_ay, r1_bx, r1_by;
    t_meter               r1_kind;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ax   <= $signed({1'b0, ax}) - $signed({1'b0, cx});
            r1_ay   <= $signed({1'b0, ay}) - $signed({1'b0, cy});
            r1_bx   <= $signed({1'b0, bx}) - $signed({1'b0, cx});
            r1_by   <= $signed({1'b0, by}) - $signed({1'b0, cy});
            r1_kind <= t_meter'(s_axis_tuser);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squared distances of both endpoints from the centre. The
    // differences are widened before they are multiplied.
    // ------------------------------------------------------------------
    logic signed [SQ_W-1:0] n2_sqa, n2_sqb;
    logic signed [SQ_W-1:0] r2_sqa, r2_sqb;
    logic signed [DW-1:0]   r2_ax, r2_ay, r2_bx, r2_by;
    t_meter                 r2_kind;

    assign n2_sqa = SQ_W'(r1_ax) * SQ_W'(r1_ax) + SQ_W'(r1_ay) * SQ_W'(r1_ay);
    assign n2_sqb = SQ_W'(r1_bx) * SQ_W'(r1_bx) + SQ_W'(r1_by) * SQ_W'(r1_by);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sqa  <= n2_sqa;
            r2_sqb  <= n2_sqb;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_kind <= r1_kind;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: choose the tip (the second endpoint wins a tie) and set up the
    // rotator. The CORDIC works on (north, east) = (-dy, dx); a vector in the
    // lower half plane is turned by half a turn first so that x starts
    // non-negative.
    // ------------------------------------------------------------------
    logic signed [DW-1:0]    dx, dy, x0, y0;
    logic signed [W-1:0]     r3_x, r3_y;
    logic signed [ACC_W-1:0] r3_acc;
    logic                    r3_zero;
    t_meter                  r3_kind;
    logic signed [ACC_W-1:0] acc0;

    always_comb begin
        if (r2_sqa > r2_sqb) begin
            dx = r2_ax;
            dy = r2_ay;
        end else begin
            dx = r2_bx;
            dy = r2_by;
        end
        if (dy > 0) begin
            x0   = dy;
            y0   = -dx;
            acc0 = HALF_TURN_FINE;
        end else begin
            x0   = -dy;
            y0   = dx;
            acc0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_x    <= W'(x0) <<< PRESCALE;
            r3_y    <= W'(y0) <<< PRESCALE;
            r3_acc  <= acc0;
            r3_zero <= (dx == 0) && (dy == 0);
            r3_kind <= r2_kind;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC stages: one micro-rotation per register stage. The meter type
    // and the zero-length flag ride alongside.
    // ------------------------------------------------------------------
    logic signed [W-1:0]     c_x   [NS+1];
    logic signed [W-1:0]     c_y   [NS+1];
    logic signed [ACC_W-1:0] c_acc [NS+1];
    logic                    r_ck_zero [NS];
    t_meter                  r_ck_kind [NS];

    assign c_x[0]   = r3_x;
    assign c_y[0]   = r3_y;
    assign c_acc[0] = r3_acc;

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        gna_cordic_stage #(
            .W   (W),
            .IDX (g)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (c_x[g]),
            .i_y   (c_y[g]),
            .i_acc (c_acc[g]),
            .o_x   (c_x[g+1]),
            .o_y   (c_y[g+1]),
            .o_acc (c_acc[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ck_zero[0] <= r3_zero;
            r_ck_kind[0] <= r3_kind;
            for (int k = 1; k < NS; k++) begin
                r_ck_zero[k] <= r_ck_zero[k-1];
                r_ck_kind[k] <= r_ck_kind[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle stage: wrap into one turn and round to 1/64 degree. A full turn
    // after rounding reads as zero.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] tot, rnd;
    logic [ANGLE_W-1:0]      ang_raw, n4_ang;
    logic [ANGLE_W-1:0]      r4_ang;
    logic                    r4_avld;
    t_meter                  r4_kind;

    assign tot     = (c_acc[NS] < 0) ? c_acc[NS] + FULL_TURN_FINE : c_acc[NS];
    assign rnd     = tot + ROUND_HALF;
    assign ang_raw = rnd[FINE_SHIFT +: ANGLE_W];

    always_comb begin
        if (r_ck_zero[NS-1] || (ang_raw == FULL_TURN_64)) begin
            n4_ang = '0;
        end else begin
            n4_ang = ang_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ang  <= n4_ang;
            r4_avld <= !r_ck_zero[NS-1];
            r4_kind <= r_ck_kind[NS-1];
        end
    end

    // ------------------------------------------------------------------
    // Segment stage: scale the angle within its arc so that full scale
    // reads 4032000 on every segment. The dead zone, an unknown meter and a
    // zero-length needle read zero.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] delta;
    logic [7:0]         slope;
    logic [M_W-1:0]     offs;
    logic               n5_pz;
    logic [M_W-1:0]     r5_m;
    logic               r5_pz;
    logic [ANGLE_W-1:0] r5_ang;
    logic               r5_avld;
    t_meter             r5_kind;

    always_comb begin
        delta = '0;
        slope = SLOPE_OUTER;
        offs  = OFF_LOW;
        n5_pz = (r4_kind == MT_UNKNOWN) || !r4_avld;
        if (r4_ang >= SEG_LOW_START && r4_ang < SEG_TOP_START) begin
            delta = r4_ang - SEG_LOW_START;
        end else if (r4_ang >= SEG_TOP_START) begin
            delta = r4_ang - SEG_TOP_START;
            slope = SLOPE_INNER;
            offs  = OFF_TOP;
        end else if (r4_ang <= RIGHT_ANGLE) begin
            delta = r4_ang;
            slope = SLOPE_INNER;
            offs  = OFF_RIGHT;
        end else if (r4_ang <= SEG_END) begin
            delta = r4_ang - RIGHT_ANGLE;
            offs  = OFF_HIGH;
        end else begin
            n5_pz = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_m    <= M_W'(M_W'(delta) * M_W'(slope)) + offs;
            r5_pz   <= n5_pz;
            r5_ang  <= r4_ang;
            r5_avld <= r4_avld;
            r5_kind <= r4_kind;
        end
    end

    // ------------------------------------------------------------------
    // Scale stage: apply the meter's full scale, the rounding bias and the
    // power-of-two part of the divisor.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] m5, sum;
    logic [V_W-1:0]   n6_v;
    logic [V_W-1:0]   r6_v;
    logic             r6_pz;
    logic [ANGLE_W-1:0] r6_ang;
    logic             r6_avld;

    assign m5 = (SUM_W'(r5_m) << 2) + SUM_W'(r5_m);

    always_comb begin
        case (r5_kind)
            MT_1_0: begin
                sum  = m5 + BIAS_1_0;
                n6_v = V_W'(sum >> SHIFT_1_0);
            end
            MT_0_25: begin
                sum  = m5 + BIAS_0_25;
                n6_v = V_W'(sum >> SHIFT_0_25);
            end
            MT_1_6: begin
                sum  = SUM_W'(r5_m) + BIAS_1_6;
                n6_v = V_W'(sum >> SHIFT_1_6);
            end
            default: begin
                sum  = '0;
                n6_v = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_v    <= n6_v;
            r6_pz   <= r5_pz;
            r6_ang  <= r5_ang;
            r6_avld <= r5_avld;
        end
    end

    // ------------------------------------------------------------------
    // Division stage: divide by 63 through the reciprocal, exact for every
    // value this path can produce.
    // ------------------------------------------------------------------
    logic [V_W+RECIP_W-1:0] prod;
    logic [PRES_W-1:0]      r7_pres;
    logic [ANGLE_W-1:0]     r7_ang;
    logic                   r7_avld;

    assign prod = (V_W+RECIP_W)'(r6_v) * (V_W+RECIP_W)'(RECIP_63);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_pres <= r6_pz ? '0 : prod[RECIP_SHIFT +: PRES_W];
            r7_ang  <= r6_ang;
            r7_avld <= r6_avld;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and the output skid register.
    // ------------------------------------------------------------------
    logic               r_sk_vld;
    logic [PRES_W-1:0]  r_sk_pres;
    logic [ANGLE_W-1:0] r_sk_ang;
    logic               r_sk_avld;

    assign en            = !r_sk_vld;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_sk_vld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[L-2:0], s_axis_tvalid};
            end
            if (r_sk_vld) begin
                if (m_axis_tready) begin
                    r_sk_vld <= 1'b0;
                end
            end else if (r_vld[L-1] && !m_axis_tready) begin
                r_sk_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sk_vld && r_vld[L-1] && !m_axis_tready) begin
            r_sk_pres <= r7_pres;
            r_sk_ang  <= r7_ang;
            r_sk_avld <= r7_avld;
        end
    end

    // The skid register, when full, holds the older item.
    assign m_axis_tvalid   = r_sk_vld || r_vld[L-1];
    assign m_axis_tdata    = r_sk_vld ? {3'b000, r_sk_pres, r_sk_ang}
                                      : {3'b000, r7_pres, r7_ang};
    assign m_axis_tuser[0] = r_sk_vld ? r_sk_avld : r7_avld;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // A zero-length needle reads zero angle and zero pressure.
    a_invalid_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tdata[14:0] == 15'd0) && (m_axis_tdata[28:15] == 14'd0))
        else $error("invalid needle with non-zero reading");

    // The angle never reaches a full turn.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:0] < FULL_TURN_64))
        else $error("needle angle out of range");

    // A finished item that is not taken is parked, never dropped.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[L-1] && !r_sk_vld && !m_axis_tready) |=> r_sk_vld)
        else $error("stalled item lost");

    // A parked item holds until it is taken.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_vld && !m_axis_tready) |=>
            (r_sk_vld && $stable(r_sk_ang) && $stable(r_sk_pres)))
        else $error("parked item changed");
`endif

endmodule

>>> dv/gauge_needle_angle_to_pressure_tb.sv
// ----------------------------------------------------------------------------
// gauge_needle_angle_to_pressure_tb: self-checking bench for the needle reader
// Streams needle segments into the block, predicts the angle and pressure of
// every accepted item with an independent CORDIC and segment model, and checks
// each reading that leaves the block in order, under random idling on both
// sides of the stream.
// ----------------------------------------------------------------------------
module gauge_needle_angle_to_pressure_tb;
    import gna_pkg::*;

    // The block's pipeline is CORDIC_STAGES + 7 register stages deep.
    localparam int PIPE_DEPTH    = CORDIC_STAGES_DEF + 7;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int FINE_PER_DEG  = 16384;
    localparam int TURN_64       = 23040;

    // Arctangent of 2^-i in 1/16384 degree, for the predicting CORDIC.
    localparam longint CORDIC_ATAN [24] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0
    };

    // One needle segment as it enters the block.
    typedef struct {
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] ax;
        logic [11:0] ay;
        logic [11:0] bx;
        logic [11:0] by;
        t_meter      meter;
    } t_needle;

    // One reading as it leaves the block.
    typedef struct {
        logic        valid;
        logic [14:0] angle;
        logic [13:0] pressure;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;  // center_x, center_y, end_a_x, end_a_y, end_b_x, end_b_y
    logic [1:0]  s_axis_tuser  = '0;  // dial_kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // needle_angle, pressure, zero fill
    logic [0:0]  m_axis_tuser;        // angle_valid

    // Readings predicted for accepted items, oldest first.
    t_reading pending_readings [$];
    int       fail_count = 0;
    // When set, neither side of the stream idles at all.
    bit       calm       = 1'b0;
    int       rx_wait    = 0;
    int       rx_gap;

    gauge_needle_angle_to_pressure u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Number of idle cycles before the next item on either side.
    function automatic int pick_gap();
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Builds a segment from absolute coordinates; values wrap to 12 bits.
    function automatic t_needle make_needle(int cx, int cy, int ax, int ay,
                                            int bx, int by, t_meter meter);
        t_needle n;
        n.cx    = 12'(cx);
        n.cy    = 12'(cy);
        n.ax    = 12'(ax);
        n.ay    = 12'(ay);
        n.bx    = 12'(bx);
        n.by    = 12'(by);
        n.meter = meter;
        return n;
    endfunction

    // Predicts the reading for one segment. The tip is the endpoint farther
    // from the centre, the second endpoint winning a tie. Its bearing is found
    // with a vectoring CORDIC on values scaled by 2^24 and turned into 1/64
    // degree; the bearing then falls into one of four linear pressure segments
    // or into the dead zone.
    function automatic t_reading read_gauge(t_needle n);
        longint   ax, ay, bx, by, dx, dy;
        longint   x, y, xs, ys, acc, ang;
        longint   fs, num, den;
        int       stages;
        t_reading r;
        ax = longint'(n.ax) - longint'(n.cx);
        ay = longint'(n.ay) - longint'(n.cy);
        bx = longint'(n.bx) - longint'(n.cx);
        by = longint'(n.by) - longint'(n.cy);
        if (ax * ax + ay * ay > bx * bx + by * by) begin
            dx = ax;
            dy = ay;
        end else begin
            dx = bx;
            dy = by;
        end
        r.valid    = 1'b0;
        r.angle    = '0;
        r.pressure = '0;
        if (dx == 0 && dy == 0) begin
            return r;
        end

        // Rows grow downward, so north is -dy; x runs north and y east.
        x   = -dy * (64'sd1 <<< 24);
        y   = dx * (64'sd1 <<< 24);
        acc = 0;
        if (x < 0) begin
            x   = -x;
            y   = -y;
            acc = 180 * FINE_PER_DEG;
        end
        stages = (CORDIC_STAGES_DEF < 24) ? CORDIC_STAGES_DEF : 24;
        for (int i = 0; i < stages; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - CORDIC_ATAN[i];
            end else begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + CORDIC_ATAN[i];
            end
        end
        if (acc < 0) begin
            acc = acc + 360 * FINE_PER_DEG;
        end
        ang = (acc + 128) >>> 8;
        if (ang >= TURN_64) begin
            ang = ang - TURN_64;
        end
        r.valid = 1'b1;
        r.angle = 15'(ang);

        case (n.meter)
            MT_1_0:  fs = 10000;
            MT_0_25: fs = 2500;
            MT_1_6:  fs = 16000;
            default: fs = 0;
        endcase
        num = 0;
        den = 1;
        if (fs == 0) begin
            num = 0;
        end else if (ang >= 14592 && ang < 17280) begin
            // Lowest segment, 228 to 270 degrees.
            num = fs * 16 * (ang - 14592);
            den = 268800;
        end else if (ang >= 17280) begin
            num = fs * (16 * 5760 + 34 * (ang - 17280));
            den = 576000;
        end else if (ang <= 5760) begin
            num = fs * (50 * 5760 + 34 * ang);
            den = 576000;
        end else if (ang <= 8448) begin
            // Highest segment, 90 to 132 degrees.
            num = fs * (84 * 2688 + 16 * (ang - 5760));
            den = 268800;
        end
        r.pressure = 14'((num + den / 2) / den);
        return r;
    endfunction

    // Offers one segment after a random pause and holds it until accepted.
    // The expected reading is queued at the edge of acceptance.
    task automatic send_needle(t_needle n);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {n.by, n.bx, n.ay, n.ax, n.cy, n.cx};
        s_axis_tuser  <= n.meter;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_readings.push_back(read_gauge(n));
    endtask

    // The receiving side stalls for a fresh random number of cycles after
    // every reading it takes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_gap = pick_gap();
            m_axis_tready <= (rx_gap == 0);
            rx_wait       <= rx_gap;
        end else if (!m_axis_tready) begin
            if (rx_wait <= 1) begin
                m_axis_tready <= 1'b1;
            end
            rx_wait <= (rx_wait > 0) ? rx_wait - 1 : 0;
        end
    end

    // Every reading taken is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: reading with none expected: valid %0d angle %0d pressure %0d",
                         $time, m_axis_tuser[0], m_axis_tdata[14:0], m_axis_tdata[28:15]);
                fail_count++;
            end else begin
                if (m_axis_tuser[0] !== pending_readings[0].valid) begin
                    $display("%0t: angle_valid expected %0d actual %0d",
                             $time, pending_readings[0].valid, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tdata[14:0] !== pending_readings[0].angle) begin
                    $display("%0t: needle_angle expected %0d actual %0d",
                             $time, pending_readings[0].angle, m_axis_tdata[14:0]);
                    fail_count++;
                end
                if (m_axis_tdata[28:15] !== pending_readings[0].pressure) begin
                    $display("%0t: pressure expected %0d actual %0d",
                             $time, pending_readings[0].pressure, m_axis_tdata[28:15]);
                    fail_count++;
                end
                void'(pending_readings.pop_front());
            end
        end
    end

    // A needle of zero length gives no angle and no pressure, wherever the
    // centre lies.
    task automatic test_zero_length();
        send_needle(make_needle(2048, 2048, 2048, 2048, 2048, 2048, MT_1_0));
        send_needle(make_needle(0, 0, 0, 0, 0, 0, MT_1_6));
        send_needle(make_needle(4095, 4095, 4095, 4095, 4095, 4095, MT_UNKNOWN));
    endtask

    // Which endpoint is taken as the tip: the farther one, the second on a tie,
    // and the other one when either endpoint sits on the centre.
    task automatic test_tip_choice();
        send_needle(make_needle(2048, 2048, 2148, 2048, 2048, 1948, MT_1_0));
        send_needle(make_needle(2048, 2048, 2548, 2048, 2048, 1948, MT_0_25));
        send_needle(make_needle(2048, 2048, 2148, 2048, 2048, 2648, MT_1_6));
        send_needle(make_needle(2048, 2048, 2048, 2048, 1500, 1700, MT_1_0));
        send_needle(make_needle(2048, 2048, 2600, 1900, 2048, 2048, MT_1_6));
    endtask

    // Compass points, diagonals and the segment ends at 132 and 228 degrees,
    // with the meter type cycling through every code including unknown.
    task automatic test_bearings();
        int east [12]  = '{0, 1000, 0, -1000, 707, -707, 707, -707, -743, 743, 1, 0};
        int south [12] = '{-1000, 0, 1000, 0, -707, -707, 707, 707, 669, 669, 0, -1};
        for (int i = 0; i < 12; i++) begin
            send_needle(make_needle(2048, 2048, 2048 + east[i], 2048 + south[i],
                                    2048, 2048, t_meter'(i % 4)));
        end
    endtask

    // Coordinates at both ends of their range give the longest needles.
    task automatic test_coordinate_extremes();
        send_needle(make_needle(0, 0, 4095, 4095, 0, 0, MT_1_0));
        send_needle(make_needle(4095, 4095, 0, 0, 4095, 4095, MT_1_6));
        send_needle(make_needle(0, 4095, 4095, 0, 0, 4095, MT_0_25));
        send_needle(make_needle(4095, 0, 4095, 0, 0, 4095, MT_1_0));
        send_needle(make_needle(2048, 4095, 2048, 0, 2048, 4000, MT_1_6));
    endtask

    // Random segments of several shapes: fully random coordinates, short
    // needles of random length round a central hub for fine bearings, ties
    // between two endpoints at the same distance, and near-zero needles.
    // Spells without any idling are mixed at random with spells of random idling.
    task automatic test_random_needles();
        int      cx, cy, u, v, w, z, span, shape;
        t_meter  meter;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            meter = t_meter'($urandom_range(0, 3));
            shape = $urandom_range(0, 9);
            cx    = $urandom_range(1100, 3000);
            cy    = $urandom_range(1100, 3000);
            if (shape < 5) begin
                send_needle(make_needle($urandom_range(0, 4095), $urandom_range(0, 4095),
                                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                                        meter));
            end else if (shape < 8) begin
                span = 1 << $urandom_range(0, 10);
                u    = $urandom_range(0, 2 * span) - span;
                v    = $urandom_range(0, 2 * span) - span;
                w    = $urandom_range(0, 2 * span) - span;
                z    = $urandom_range(0, 2 * span) - span;
                send_needle(make_needle(cx, cy, cx + u, cy + v, cx + w, cy + z, meter));
            end else if (shape == 8) begin
                // The second endpoint is the first turned by a right angle.
                u = $urandom_range(0, 2000) - 1000;
                v = $urandom_range(0, 2000) - 1000;
                send_needle(make_needle(cx, cy, cx + u, cy + v, cx - v, cy + u, meter));
            end else begin
                u = $urandom_range(0, 2) - 1;
                v = $urandom_range(0, 2) - 1;
                send_needle(make_needle(cx, cy, cx + u, cy + v, cx, cy, meter));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length();
        test_tip_choice();
        test_bearings();
        test_coordinate_extremes();
        test_random_needles();
        s_axis_tvalid <= 1'b0;

        // Let the pipeline drain, then allow a little longer for strays.
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("gauge_needle_angle_to_pressure verification clean");
        end else begin
            $display("gauge_needle_angle_to_pressure verification failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20000000;
        $display("gauge_needle_angle_to_pressure verification failed");
        $finish;
    end

endmodule

>>> sim.f
design/gna_pkg.sv
design/gna_cordic_stage.sv
design/gauge_needle_angle_to_pressure.sv
dv/gauge_needle_angle_to_pressure_tb.sv
